>>> rtl/core/chkv_pkg.sv
// Package: shared types, constants and the shift-xor step of the key hash
package chkv_pkg;
    localparam int DefaultBuckets = 1024;
    localparam int DefaultPool    = 1024;

    typedef enum logic [1:0] {
        KIND_PUT = 2'd0,
        KIND_GET = 2'd1,
        KIND_DEL = 2'd2,
        KIND_NOP = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_HEAD,
        BS_HEAD_WAIT,
        BS_NODE,
        BS_NODE_WAIT,
        BS_CHECK,
        BS_FREE,
        BS_FREE_WAIT,
        BS_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] hash;
    } cmd_t;

    function automatic logic [31:0] shift_xor(input logic [31:0] h, input int unsigned s);
        shift_xor = h ^ (h >> s);
    endfunction
endpackage

>>> rtl/core/chkv_if.sv
// Interfaces: valid/ready channels for requests and responses
interface chkv_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [31:0] lookup_key;
    logic signed [31:0] put_value;
    modport source (output valid, kind, lookup_key, put_value, input ready);
    modport sink   (input valid, kind, lookup_key, put_value, output ready);
endinterface

interface chkv_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

>>> rtl/core/chkv_front.sv
// Front end: accepts requests and computes the key hash in a registered pipeline
module chkv_front (
    input  logic clk,
    input  logic rst_n,
    chkv_req_if.sink req,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output chkv_pkg::cmd_t    cmd
);
    import chkv_pkg::*;

    logic [2:0]  vld_reg;
    logic [31:0] h_reg [3];
    logic [1:0]  kind_reg [3];
    logic [31:0] key_reg [3];
    logic [31:0] val_reg [3];
    logic        adv;

    assign adv = !vld_reg[2] || cmd_ready;
    assign req.ready = adv;
    assign cmd_valid = vld_reg[2];
    assign cmd.kind  = kind_reg[2];
    assign cmd.key   = key_reg[2];
    assign cmd.value = val_reg[2];
    assign cmd.hash  = shift_xor(h_reg[2], 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg[0]    <= shift_xor(req.lookup_key, 16) * 32'h85ebca6b;
            h_reg[1]    <= shift_xor(h_reg[0], 13) * 32'hc2b2ae35;
            h_reg[2]    <= h_reg[1];
            kind_reg[0] <= req.kind;
            key_reg[0]  <= req.lookup_key;
            val_reg[0]  <= req.put_value;
            for (int i = 1; i < 3; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
                key_reg[i]  <= key_reg[i-1];
                val_reg[i]  <= val_reg[i-1];
            end
        end
    end
endmodule

>>> rtl/core/chkv_queue.sv
// Queue: two-entry command buffer between front and back end
module chkv_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  chkv_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output chkv_pkg::cmd_t out_cmd
);
    import chkv_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule

>>> rtl/core/chkv_back.sv
// Back end: bucket and node memories with the chain walk sequencer
module chkv_back #(
    parameter int NUM_BUCKETS  = chkv_pkg::DefaultBuckets,
    parameter int POOL_ENTRIES = chkv_pkg::DefaultPool
) (
    input  logic clk,
    input  logic rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  chkv_pkg::cmd_t cmd,
    chkv_rsp_if.source rsp
);
    import chkv_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int NW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_ENTRIES);

    logic [NW-1:0] heads_mem [NUM_BUCKETS];
    logic [31:0]   keys_mem  [POOL_ENTRIES];
    logic [31:0]   vals_mem  [POOL_ENTRIES];
    logic [NW-1:0] links_mem [POOL_ENTRIES];

    back_state_t   state_reg, state_next;
    cmd_t          c_reg;
    logic [BW-1:0] bkt_reg;
    logic [BW:0]   clr_reg;
    logic [NW-1:0] cur_reg, prev_reg, free_reg, fresh_reg, walk_reg;
    logic [NW-1:0] head_rd_reg, link_rd_reg;
    logic [NW-1:0] nxt_reg;
    logic [31:0]   key_rd_reg, val_rd_reg;
    logic [1:0]    st_reg;
    logic [31:0]   fv_reg;
    logic          rsp_vld_reg;
    logic [BW-1:0] cbkt;

    assign cbkt = cmd.hash[BW-1:0];
    assign cmd_ready = state_reg == BS_IDLE && !rsp_vld_reg;
    assign rsp.valid = rsp_vld_reg;
    assign rsp.status = st_reg;
    assign rsp.found_value = fv_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_CLEAR:     if (clr_reg == (BW+1)'(NUM_BUCKETS - 1)) state_next = BS_IDLE;
            BS_IDLE:      if (cmd_valid && cmd_ready) state_next = BS_HEAD;
            BS_HEAD:      state_next = BS_HEAD_WAIT;
            BS_HEAD_WAIT: state_next = BS_CHECK;
            BS_NODE:      state_next = BS_NODE_WAIT;
            BS_NODE_WAIT: state_next = BS_CHECK;
            BS_CHECK:
            begin
                if (cur_reg == NIL || walk_reg == NIL) state_next = BS_FREE;
                else state_next = BS_NODE;
            end
            BS_FREE:      state_next = BS_FREE_WAIT;
            BS_FREE_WAIT: state_next = BS_IDLE;
            BS_DONE:      state_next = BS_IDLE;
            default:      state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BS_CLEAR;
            clr_reg     <= '0;
            free_reg    <= NIL;
            fresh_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.valid && rsp.ready) rsp_vld_reg <= 1'b0;
            if (state_reg == BS_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == BS_FREE_WAIT)
            begin
                rsp_vld_reg <= 1'b1;
                if (c_reg.kind == KIND_PUT && cur_reg == NIL)
                begin
                    if (free_reg != NIL) free_reg <= link_rd_reg;
                    else if (fresh_reg != NIL) fresh_reg <= fresh_reg + 1'b1;
                end
                else if (c_reg.kind == KIND_DEL && cur_reg != NIL)
                begin
                    free_reg <= cur_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_CLEAR) heads_mem[clr_reg[BW-1:0]] <= NIL;
        head_rd_reg <= heads_mem[bkt_reg];
        key_rd_reg  <= keys_mem[cur_reg[AW-1:0]];
        val_rd_reg  <= vals_mem[cur_reg[AW-1:0]];
        link_rd_reg <= links_mem[(state_reg == BS_FREE) ? free_reg[AW-1:0] : cur_reg[AW-1:0]];
        case (state_reg)
            BS_IDLE:
            begin
                c_reg    <= cmd;
                bkt_reg  <= cbkt;
                prev_reg <= NIL;
                walk_reg <= '0;
            end
            BS_HEAD_WAIT:
            begin
                cur_reg <= head_rd_reg;
            end
            BS_NODE_WAIT:
            begin
                if (key_rd_reg == c_reg.key) walk_reg <= NIL;
                else
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= link_rd_reg;
                    walk_reg <= walk_reg + 1'b1;
                end
            end
            BS_FREE_WAIT:
            begin
                st_reg <= ST_NOTFOUND;
                fv_reg <= '0;
                case (c_reg.kind)
                    KIND_PUT:
                    begin
                        if (cur_reg != NIL)
                        begin
                            vals_mem[cur_reg[AW-1:0]] <= c_reg.value;
                            st_reg <= ST_OK;
                        end
                        else if (free_reg != NIL || fresh_reg != NIL)
                        begin
                            keys_mem[(free_reg != NIL) ? free_reg[AW-1:0] : fresh_reg[AW-1:0]]
                                <= c_reg.key;
                            vals_mem[(free_reg != NIL) ? free_reg[AW-1:0] : fresh_reg[AW-1:0]]
                                <= c_reg.value;
                            links_mem[(free_reg != NIL) ? free_reg[AW-1:0] : fresh_reg[AW-1:0]]
                                <= head_rd_reg;
                            heads_mem[bkt_reg] <= (free_reg != NIL) ? free_reg : fresh_reg;
                            st_reg <= ST_OK;
                        end
                        else st_reg <= ST_FULL;
                    end
                    KIND_GET:
                    begin
                        if (cur_reg != NIL)
                        begin
                            st_reg <= ST_OK;
                            fv_reg <= val_rd_reg;
                        end
                    end
                    KIND_DEL:
                    begin
                        if (cur_reg != NIL)
                        begin
                            st_reg <= ST_OK;
                            fv_reg <= val_rd_reg;
                            if (prev_reg != NIL) links_mem[prev_reg[AW-1:0]] <= nxt_reg;
                            else heads_mem[bkt_reg] <= nxt_reg;
                            links_mem[cur_reg[AW-1:0]] <= free_reg;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_FREE) nxt_reg <= link_rd_reg;
    end
endmodule

>>> rtl/core/chained_hash_key_value_store.sv
// Chained hash key-value store: one status response per request, no-ops included.
// The front end hashes the key in a registered pipeline and the queue buffers the
// command. The back end takes the command, reads the bucket head (HEAD, HEAD_WAIT),
// checks it (CHECK), and walks the chain node by node (NODE read, NODE_WAIT compare,
// CHECK), then reads the free list and does the update (FREE, FREE_WAIT). The back end
// takes the next command only once the response has been accepted, so it never works
// on two commands at once. NUM_BUCKETS must be a power of two, since the bucket is the
// low hash bits. After reset a clearing pass empties every bucket head before the back
// end takes any command.
module chained_hash_key_value_store #(
    parameter int NUM_BUCKETS  = chkv_pkg::DefaultBuckets,
    parameter int POOL_ENTRIES = chkv_pkg::DefaultPool
) (
    input  logic clk,
    input  logic rst_n,
    chkv_req_if.sink   req,
    chkv_rsp_if.source rsp
);
    import chkv_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    chkv_front u_front (.clk, .rst_n, .req, .cmd_valid(f_valid), .cmd_ready(f_ready),
                        .cmd(f_cmd));
    chkv_queue u_queue (.clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
                        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));
    chkv_back #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
        .clk, .rst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd), .rsp);
endmodule

>>> rtl/core/chkv_checker.sv
// Checker: port-level properties of the key-value store, bound to the top level
module chkv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_found_value
);
    import chkv_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)) else $error("rsp hold");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_found_value == '0) else $error("value");
endmodule

bind chained_hash_key_value_store chkv_checker u_chk (.clk, .rst_n, .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready), .rsp_status(rsp.status), .rsp_found_value(rsp.found_value));

>>> tb/tb.sv
// Testbench for chained_hash_key_value_store: directed and random put/get/delete/no-op traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chkv_pkg::*;

    localparam int BUCKETS = 1024;
    localparam int POOL    = 1024;
    localparam int NIL     = POOL;

    typedef struct {
        status_t     status;
        logic [31:0] value;
    } reply_t;

    class kv_scoreboard;
        int          heads [BUCKETS];
        logic [31:0] keys  [POOL];
        logic [31:0] vals  [POOL];
        int          links [POOL];
        int          free_head;
        int          fresh_mark;
        reply_t      replies [$];
        int          errors;

        function void clear();
            foreach (heads[i]) heads[i] = NIL;
            free_head = NIL;
            fresh_mark = 0;
            errors = 0;
        endfunction

        function int bucket_of(logic [31:0] k);
            logic [31:0] h;
            h = k ^ (k >> 16);
            h = h * 32'h85ebca6b;
            h = h ^ (h >> 13);
            h = h * 32'hc2b2ae35;
            h = h ^ (h >> 16);
            return int'(h % BUCKETS);
        endfunction

        function void note(kind_t kind, logic [31:0] k, logic [31:0] v);
            int b;
            int cur;
            int prev;
            int steps;
            int slot;
            reply_t r;
            b = bucket_of(k);
            cur = heads[b];
            prev = NIL;
            steps = 0;
            while (cur != NIL && steps < POOL && keys[cur] != k)
            begin
                prev = cur;
                cur = links[cur];
                steps++;
            end
            if (steps >= POOL)
                cur = NIL;
            r.status = ST_NOTFOUND;
            r.value = '0;
            case (kind)
                KIND_PUT:
                begin
                    if (cur != NIL)
                    begin
                        vals[cur] = v;
                        r.status = ST_OK;
                    end
                    else
                    begin
                        slot = NIL;
                        if (free_head != NIL)
                        begin
                            slot = free_head;
                            free_head = links[slot];
                        end
                        else if (fresh_mark < POOL)
                        begin
                            slot = fresh_mark;
                            fresh_mark++;
                        end
                        if (slot != NIL)
                        begin
                            keys[slot] = k;
                            vals[slot] = v;
                            links[slot] = heads[b];
                            heads[b] = slot;
                            r.status = ST_OK;
                        end
                        else
                            r.status = ST_FULL;
                    end
                end
                KIND_GET:
                begin
                    if (cur != NIL)
                    begin
                        r.status = ST_OK;
                        r.value = vals[cur];
                    end
                end
                KIND_DEL:
                begin
                    if (cur != NIL)
                    begin
                        r.status = ST_OK;
                        r.value = vals[cur];
                        if (prev != NIL)
                            links[prev] = links[cur];
                        else
                            heads[b] = links[cur];
                        links[cur] = free_head;
                        free_head = cur;
                    end
                end
                default: ;
            endcase
            replies.push_back(r);
        endfunction

        function void check(logic [1:0] status, logic [31:0] value);
            reply_t r;
            if (replies.size() == 0)
            begin
                $error("unexpected response status=%0d found_value=%h", status, value);
                errors++;
                return;
            end
            r = replies.pop_front();
            if (status !== r.status)
            begin
                $error("status expected %0d actual %0d", r.status, status);
                errors++;
            end
            if (value !== r.value)
            begin
                $error("found_value expected %h actual %h", r.value, value);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_mode;
    logic [31:0] known_keys [$];
    kv_scoreboard store_model;

    chkv_req_if req ();
    chkv_rsp_if rsp ();

    chained_hash_key_value_store DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int idle_pct(bit sender);
        case (idle_mode)
            1: return sender ? 50 : 0;
            2: return sender ? 0 : 50;
            3: return 38;
            default: return 0;
        endcase
    endfunction

    always @(negedge clk)
        rsp.ready <= rst_n && ($urandom_range(99) >= idle_pct(1'b0));

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            store_model.check(rsp.status, rsp.found_value);

    task automatic send(kind_t kind, logic [31:0] k, logic [31:0] v);
        if ($urandom_range(99) < idle_pct(1'b1))
        begin
            @(negedge clk);
            req.valid = 1'b0;
            while ($urandom_range(99) < idle_pct(1'b1))
                @(negedge clk);
        end
        @(negedge clk);
        req.valid = 1'b1;
        req.kind = kind;
        req.lookup_key = k;
        req.put_value = v;
        do
            @(posedge clk);
        while (!req.ready);
        store_model.note(kind, k, v);
        if (kind == KIND_PUT)
            known_keys.push_back(k);
    endtask

    function logic [31:0] pick_key(int pct_known);
        if (known_keys.size() > 0 && $urandom_range(99) < pct_known)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int pct_known, int pct_put);
        int r;
        kind_t kind;
        r = $urandom_range(99);
        if (r < 2)
            kind = KIND_NOP;
        else if (r < 2 + pct_put)
            kind = KIND_PUT;
        else if (r < 2 + pct_put + (98 - pct_put) / 2)
            kind = KIND_GET;
        else
            kind = KIND_DEL;
        send(kind, pick_key(pct_known), $urandom);
    endtask

    initial
    begin
        #5ms;
        $display("chained_hash_key_value_store test failed");
        $finish;
    end

    initial
    begin
        int n;
        store_model = new();
        store_model.clear();
        idle_mode = 0;
        req.valid = 1'b0;
        req.kind = KIND_PUT;
        req.lookup_key = '0;
        req.put_value = '0;
        rsp.ready = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(KIND_GET, 32'h0000_0000, 32'h0);
        send(KIND_PUT, 32'h0000_0000, 32'h7fff_ffff);
        send(KIND_PUT, 32'h8000_0000, 32'h8000_0000);
        send(KIND_PUT, 32'h7fff_ffff, 32'hffff_ffff);
        send(KIND_PUT, 32'hffff_ffff, 32'h0000_0000);
        send(KIND_GET, 32'h0000_0000, 32'hffff_ffff);
        send(KIND_GET, 32'h8000_0000, 32'h0);
        send(KIND_GET, 32'h7fff_ffff, 32'h0);
        send(KIND_GET, 32'hffff_ffff, 32'h0);
        send(KIND_PUT, 32'h8000_0000, 32'h1234_5678);
        send(KIND_GET, 32'h8000_0000, 32'h0);
        send(KIND_DEL, 32'h7fff_ffff, 32'h0);
        send(KIND_DEL, 32'h7fff_ffff, 32'h0);
        send(KIND_GET, 32'h7fff_ffff, 32'h0);
        send(KIND_NOP, 32'h8000_0000, 32'hffff_ffff);
        send(KIND_GET, 32'h8000_0000, 32'h0);
        send(KIND_PUT, 32'h0000_0001, 32'h5555_5555);
        send(KIND_PUT, 32'haaaa_aaaa, 32'haaaa_aaaa);
        send(KIND_DEL, 32'h0000_0000, 32'h0);
        send(KIND_GET, 32'haaaa_aaaa, 32'h0);

        for (n = 0; n < 400; n++)
        begin
            idle_mode = (n / 100) % 4;
            send_random(60, 40);
        end
        for (n = 0; n < 1050; n++)
        begin
            idle_mode = (n / 260) % 4;
            if ($urandom_range(19) == 0)
                send_random(80, 20);
            else
                send(KIND_PUT, $urandom, $urandom);
        end
        for (n = 0; n < 500; n++)
        begin
            idle_mode = (n / 125) % 4;
            send_random(80, 35);
        end

        @(negedge clk);
        req.valid = 1'b0;
        idle_mode = 0;
        n = 0;
        while (store_model.replies.size() > 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (100) @(posedge clk);
        if (store_model.errors == 0 && store_model.replies.size() == 0)
            $display("chained_hash_key_value_store test passed");
        else
            $display("chained_hash_key_value_store test failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/chkv_pkg.sv
rtl/core/chkv_if.sv
rtl/core/chkv_front.sv
rtl/core/chkv_queue.sv
rtl/core/chkv_back.sv
rtl/core/chained_hash_key_value_store.sv
rtl/core/chkv_checker.sv
tb/tb.sv
